// File: rtl/core/sspi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and filter functions for the six-tap sub-pel interpolator.
package sspi_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_HEIGHT_EFF = 26;
    localparam int PIX_W          = 8;
    localparam int SUB_W          = 3;
    localparam int DIM_W          = 5;
    localparam int ROW_W          = 5;
    localparam int NTAPS          = 6;
    localparam int LINE_ROWS      = 5;
    localparam int LEAD           = 5;
    localparam int ROUND          = 64;
    localparam int SHIFT          = 7;
    localparam int PIX_MAX        = 255;
    localparam int PROD_W         = 18;
    localparam int SUM_W          = 18;
    localparam int TAP_W          = 9;
    localparam int JOB_DEPTH      = 4;
    localparam int OUT_DEPTH      = 8;
    localparam int BACK_STAGES    = 4;
    localparam int DIM_RESET      = 16;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 1'd1;

    typedef logic [NTAPS-1:0][TAP_W-1:0] t_tap_row;
    typedef logic [NTAPS-1:0][PIX_W-1:0] t_pix_row;

    // One classified window word on its way from the front to the back.
    typedef struct packed {
        t_pix_row          hs;
        logic [SUB_W-1:0]  sel_x;
        logic [SUB_W-1:0]  sel_y;
        logic              has_h;
        logic              produce;
        logic              done;
    } t_job;

    // Element k of the row is the tap applied to the k-th oldest sample.
    function automatic t_tap_row tap_row(input logic [SUB_W-1:0] sel);
        t_tap_row r;
        unique case (sel)
            3'd0: r = {9'sd0, 9'sd0, 9'sd0, 9'sd128, 9'sd0, 9'sd0};
            3'd1: r = {9'sd0, -9'sd1, 9'sd12, 9'sd123, -9'sd6, 9'sd0};
            3'd2: r = {9'sd1, -9'sd8, 9'sd36, 9'sd108, -9'sd11, 9'sd2};
            3'd3: r = {9'sd0, -9'sd6, 9'sd50, 9'sd93, -9'sd9, 9'sd0};
            3'd4: r = {9'sd3, -9'sd16, 9'sd77, 9'sd77, -9'sd16, 9'sd3};
            3'd5: r = {9'sd0, -9'sd9, 9'sd93, 9'sd50, -9'sd6, 9'sd0};
            3'd6: r = {9'sd2, -9'sd11, 9'sd108, 9'sd36, -9'sd8, 9'sd1};
            3'd7: r = {9'sd0, -9'sd6, 9'sd123, 9'sd12, -9'sd1, 9'sd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Adds the rounding constant, scales down and saturates to a pixel.
    function automatic logic [PIX_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0]     v;
        logic [SUM_W-SHIFT-1:0]    sh;
        logic [PIX_W-1:0]          res;
        v  = $signed({s[SUM_W-1], s}) + $signed((SUM_W + 1)'(ROUND));
        sh = v[SUM_W-1:SHIFT];
        if (v[SUM_W]) begin
            res = '0;
        end else if (sh > (SUM_W - SHIFT)'(PIX_MAX)) begin
            res = PIX_W'(PIX_MAX);
        end else begin
            res = sh[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/sspi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sspi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sspi_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO with valid/ready on both sides and an occupancy count.
module sspi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push_valid,
    output logic                       o_push_ready,
    input  logic [WIDTH-1:0]           i_push_data,
    output logic                       o_pop_valid,
    input  logic                       i_pop_ready,
    output logic [WIDTH-1:0]           o_pop_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_data[r_rptr];
    assign o_count      = r_count;

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/core/sspi_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, window position tracking and word classification.
module sspi_front #(
    parameter int MAX_WIDTH = sspi_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sspi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sspi_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sspi_pkg::PIX_W-1:0]         i_ref_pixel,
    input  logic [sspi_pkg::SUB_W-1:0]         i_sub_x,
    input  logic [sspi_pkg::SUB_W-1:0]         i_sub_y,
    output logic                               o_job_valid,
    input  logic                               i_job_ready,
    output sspi_pkg::t_job                     o_job,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_job_col
);

    localparam int COL_W  = $clog2(MAX_WIDTH + sspi_pkg::LEAD);
    localparam int WCMP_W = (COL_W > sspi_pkg::DIM_W) ? COL_W : sspi_pkg::DIM_W;
    localparam int J_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W  = sspi_pkg::ROW_W;

    logic [sspi_pkg::DIM_W-1:0]             r_block_width;
    logic [sspi_pkg::DIM_W-1:0]             r_block_height;
    logic [COL_W-1:0]                       r_col;
    logic [ROW_W-1:0]                       r_row;
    logic [sspi_pkg::SUB_W-1:0]             r_sub_x;
    logic [sspi_pkg::SUB_W-1:0]             r_sub_y;
    logic [sspi_pkg::LINE_ROWS-1:0][sspi_pkg::PIX_W-1:0] r_shift;

    logic [WCMP_W-1:0] w_cmp, w_eff, last_col_w;
    logic [COL_W-1:0]  last_col, col;
    logic [ROW_W-1:0]  h_eff, last_row, row;
    logic              first, accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_job_ready;
    assign o_job_valid = i_valid;
    assign accept      = i_valid && i_job_ready;

    // Out-of-range sizes are pinned to the nearest supported size.
    always_comb begin
        w_cmp = WCMP_W'(r_block_width);
        if (w_cmp == '0) begin
            w_eff = WCMP_W'(1);
        end else if (w_cmp > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_cmp;
        end
        last_col_w = w_eff + WCMP_W'(sspi_pkg::LEAD - 1);
        last_col   = last_col_w[COL_W-1:0];

        if (r_block_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (r_block_height > ROW_W'(sspi_pkg::MAX_HEIGHT_EFF)) begin
            h_eff = ROW_W'(sspi_pkg::MAX_HEIGHT_EFF);
        end else begin
            h_eff = r_block_height;
        end
        last_row = h_eff + ROW_W'(sspi_pkg::LEAD - 1);

        // A size shrunk mid-window leaves the position on the new last column or row.
        col   = (r_col > last_col) ? last_col : r_col;
        row   = (r_row > last_row) ? last_row : r_row;
        first = (col == '0) && (row == '0);
    end

    always_comb begin
        o_job.hs      = {i_ref_pixel, r_shift};
        o_job.sel_x   = first ? i_sub_x : r_sub_x;
        o_job.sel_y   = first ? i_sub_y : r_sub_y;
        o_job.has_h   = (col >= COL_W'(sspi_pkg::LEAD));
        o_job.produce = (col >= COL_W'(sspi_pkg::LEAD)) && (row >= ROW_W'(sspi_pkg::LEAD));
        o_job.done    = (col == last_col) && (row == last_row);
        o_job_col     = J_W'(col - COL_W'(sspi_pkg::LEAD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width  <= sspi_pkg::DIM_W'(sspi_pkg::DIM_RESET);
            r_block_height <= sspi_pkg::DIM_W'(sspi_pkg::DIM_RESET);
            r_col          <= '0;
            r_row          <= '0;
            r_sub_x        <= '0;
            r_sub_y        <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sspi_pkg::REG_BLOCK_WIDTH:  r_block_width  <= i_cfg_data;
                    sspi_pkg::REG_BLOCK_HEIGHT: r_block_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (first) begin
                    r_sub_x <= i_sub_x;
                    r_sub_y <= i_sub_y;
                end
                if (col >= last_col) begin
                    r_col <= '0;
                    r_row <= (row >= last_row) ? '0 : row + ROW_W'(1);
                end else begin
                    r_col <= col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shift <= {i_ref_pixel, r_shift[sspi_pkg::LINE_ROWS-1:1]};
        end
    end

endmodule

// File: rtl/core/sspi_back.sv
`timescale 1ns / 1ps
// Back end: horizontal filter, line store update, vertical filter and result queue.
module sspi_back #(
    parameter int MAX_WIDTH = sspi_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  sspi_pkg::t_job                i_job,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_job_col,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sspi_pkg::PIX_W-1:0]    o_pred_pixel,
    output logic                          o_block_done
);

    localparam int J_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W  = sspi_pkg::PIX_W;
    localparam int LS_W   = sspi_pkg::LINE_ROWS * PIX_W;
    localparam int OCNT_W = $clog2(sspi_pkg::OUT_DEPTH + 1);
    localparam int RES_W  = $clog2(sspi_pkg::OUT_DEPTH + sspi_pkg::BACK_STAGES + 1);
    localparam int NT     = sspi_pkg::NTAPS;

    typedef struct packed {
        logic                       has_h;
        logic                       produce;
        logic                       done;
        logic [sspi_pkg::SUB_W-1:0] sel_y;
    } t_ctl;

    // Stage 1: line store read in flight.
    logic                          r_s1_valid;
    sspi_pkg::t_job                r_s1_job;
    logic [J_W-1:0]                r_s1_col;
    // Stage 2: horizontal products and the stored column.
    logic                          r_s2_valid;
    t_ctl                          r_s2_ctl;
    logic [J_W-1:0]                r_s2_col;
    logic signed [sspi_pkg::PROD_W-1:0] r_s2_prod [NT];
    logic [LS_W-1:0]               r_s2_vs;
    // Stage 3: full vertical neighborhood.
    logic                          r_s3_valid;
    t_ctl                          r_s3_ctl;
    sspi_pkg::t_pix_row            r_s3_vcol;
    // Stage 4: vertical products.
    logic                          r_s4_valid;
    t_ctl                          r_s4_ctl;
    logic signed [sspi_pkg::PROD_W-1:0] r_s4_prod [NT];

    logic                          pop;
    logic [LS_W-1:0]               ram_rdata;
    logic signed [sspi_pkg::SUM_W-1:0] hsum, vsum;
    logic [PIX_W-1:0]              hval, pred;
    sspi_pkg::t_tap_row            htaps, vtaps;
    logic [OCNT_W-1:0]             out_count;
    logic [RES_W-1:0]              reserved;
    logic                          out_push;

    // Every word in flight holds a slot in the result queue, so the stages never stall.
    assign reserved = RES_W'(out_count) + RES_W'(r_s1_valid) + RES_W'(r_s2_valid)
                    + RES_W'(r_s3_valid) + RES_W'(r_s4_valid);
    assign o_job_ready = (reserved < RES_W'(sspi_pkg::OUT_DEPTH));
    assign pop         = i_job_valid && o_job_ready;

    sspi_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid && r_s2_ctl.has_h),
        .i_waddr (r_s2_col),
        .i_wdata ({hval, r_s2_vs[LS_W-1:PIX_W]}),
        .i_re    (pop && i_job.has_h),
        .i_raddr (i_job_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        htaps = sspi_pkg::tap_row(r_s1_job.sel_x);
        vtaps = sspi_pkg::tap_row(r_s3_ctl.sel_y);
        hsum  = '0;
        vsum  = '0;
        for (int k = 0; k < NT; k++) begin
            hsum = hsum + r_s2_prod[k];
            vsum = vsum + r_s4_prod[k];
        end
        hval = sspi_pkg::round_clamp(hsum);
        pred = sspi_pkg::round_clamp(vsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_job <= i_job;
            r_s1_col <= i_job_col;
        end
        r_s2_ctl.has_h   <= r_s1_job.has_h;
        r_s2_ctl.produce <= r_s1_job.produce;
        r_s2_ctl.done    <= r_s1_job.done;
        r_s2_ctl.sel_y   <= r_s1_job.sel_y;
        r_s2_col         <= r_s1_col;
        r_s2_vs          <= ram_rdata;
        for (int k = 0; k < NT; k++) begin
            r_s2_prod[k] <= $signed(htaps[k]) * $signed({1'b0, r_s1_job.hs[k]});
        end
        r_s3_ctl  <= r_s2_ctl;
        r_s3_vcol <= {hval, r_s2_vs};
        r_s4_ctl  <= r_s3_ctl;
        for (int k = 0; k < NT; k++) begin
            r_s4_prod[k] <= $signed(vtaps[k]) * $signed({1'b0, r_s3_vcol[k]});
        end
    end

    assign out_push = r_s4_valid && r_s4_ctl.produce;

    sspi_fifo #(
        .WIDTH (PIX_W + 1),
        .DEPTH (sspi_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (out_push),
        .o_push_ready (),
        .i_push_data  ({pred, r_s4_ctl.done}),
        .o_pop_valid  (o_valid),
        .i_pop_ready  (i_ready),
        .o_pop_data   ({o_pred_pixel, o_block_done}),
        .o_count      (out_count)
    );

endmodule

// File: rtl/core/sixtap_subpel_interpolator.sv
`timescale 1ns / 1ps
// Top level of the six-tap sub-pel interpolator.
//
// The input channel takes the (W+5)x(H+5) reference window in raster order, one
// pixel word per cycle, sustained while the receiver keeps up; sub_x and sub_y are
// sampled with the first word of a window. The output channel gives one predicted
// pixel for every window word that completes a 6x6 neighborhood, in raster order,
// with block_done set on the last one of the block. Block width and height are
// written through the configuration channel (index 0 and 1), which is always
// ready; the user must write them only while the block is idle, which the block
// does not enforce. An accepted word passes through the front queue, the line
// store read and the horizontal products, the horizontal sum, the vertical
// products and the vertical sum into the result queue. The line store is read
// and rewritten at one column for each word from the sixth column of a row on.
// When the receiver stalls, results collect in an 8-word queue; input is
// refused once words in flight would overrun it, and resumes when it drains.
// Synchronous reset sets both sizes to 16, rewinds the window position and
// empties all queues; the line store needs no clearing.
module sixtap_subpel_interpolator #(
    parameter int MAX_WIDTH = sspi_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sspi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sspi_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sspi_pkg::PIX_W-1:0]     i_ref_pixel,
    input  logic [sspi_pkg::SUB_W-1:0]     i_sub_x,
    input  logic [sspi_pkg::SUB_W-1:0]     i_sub_y,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sspi_pkg::PIX_W-1:0]     o_pred_pixel,
    output logic                           o_block_done
);

    localparam int J_W   = $clog2(MAX_WIDTH);
    localparam int JOB_W = $bits(sspi_pkg::t_job) + J_W;

    logic           f_job_valid, f_job_ready;
    sspi_pkg::t_job f_job;
    logic [J_W-1:0] f_job_col;
    logic           b_job_valid, b_job_ready;
    sspi_pkg::t_job b_job;
    logic [J_W-1:0] b_job_col;

    sspi_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ref_pixel (i_ref_pixel),
        .i_sub_x     (i_sub_x),
        .i_sub_y     (i_sub_y),
        .o_job_valid (f_job_valid),
        .i_job_ready (f_job_ready),
        .o_job       (f_job),
        .o_job_col   (f_job_col)
    );

    sspi_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (sspi_pkg::JOB_DEPTH)
    ) u_job_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .o_push_ready (f_job_ready),
        .i_push_data  ({f_job_col, f_job}),
        .o_pop_valid  (b_job_valid),
        .i_pop_ready  (b_job_ready),
        .o_pop_data   ({b_job_col, b_job}),
        .o_count      ()
    );

    sspi_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (b_job_valid),
        .o_job_ready  (b_job_ready),
        .i_job        (b_job),
        .i_job_col    (b_job_col),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pred_pixel (o_pred_pixel),
        .o_block_done (o_block_done)
    );

endmodule

// File: verif/sixtap_subpel_interpolator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the six-tap sub-pel interpolator: directed windows, then random ones.
module sixtap_subpel_interpolator_tb;
    import sspi_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 150;
    localparam int DRAIN_CYCLES   = 10;
    localparam int NUM_DIRECTED   = 12;

    typedef enum logic [2:0] {
        FILL_FLAT,
        FILL_STRIPES,
        FILL_RAMP,
        FILL_NOISE,
        FILL_BINARY
    } t_fill;

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_BURSTY,
        PACE_SPARSE
    } t_pace;

    // One directed window: which size registers to write, offsets, pixel fill and,
    // for flat windows, the level every predicted pixel must have.
    typedef struct packed {
        logic [1:0]       wr_mask;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [SUB_W-1:0] sx;
        logic [SUB_W-1:0] sy;
        t_fill            fill;
        logic [PIX_W-1:0] level;
        logic             fixed;
    } t_window_spec;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             done;
    } t_pred_word;

    localparam t_window_spec DIRECTED [NUM_DIRECTED] = '{
        '{2'b00, 5'd16, 5'd16, 3'd0, 3'd0, FILL_FLAT,    8'd255, 1'b1},
        '{2'b11, 5'd4,  5'd4,  3'd7, 3'd7, FILL_FLAT,    8'd0,   1'b1},
        '{2'b00, 5'd4,  5'd4,  3'd4, 3'd4, FILL_FLAT,    8'd255, 1'b1},
        '{2'b10, 5'd4,  5'd8,  3'd4, 3'd0, FILL_STRIPES, 8'd0,   1'b0},
        '{2'b11, 5'd8,  5'd4,  3'd0, 3'd4, FILL_STRIPES, 8'd0,   1'b0},
        '{2'b11, 5'd4,  5'd4,  3'd0, 3'd0, FILL_RAMP,    8'd0,   1'b0},
        '{2'b11, 5'd0,  5'd0,  3'd3, 3'd5, FILL_NOISE,   8'd0,   1'b0},
        '{2'b11, 5'd31, 5'd1,  3'd2, 3'd2, FILL_FLAT,    8'd128, 1'b1},
        '{2'b11, 5'd0,  5'd4,  3'd6, 3'd6, FILL_NOISE,   8'd0,   1'b0},
        '{2'b11, 5'd17, 5'd1,  3'd5, 3'd1, FILL_BINARY,  8'd0,   1'b0},
        '{2'b11, 5'd4,  5'd4,  3'd4, 3'd4, FILL_STRIPES, 8'd0,   1'b0},
        '{2'b11, 5'd1,  5'd27, 3'd1, 3'd3, FILL_BINARY,  8'd0,   1'b0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_BLOCK_WIDTH;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_ref_pixel = '0;
    logic [SUB_W-1:0]     i_sub_x     = '0;
    logic [SUB_W-1:0]     i_sub_y     = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [PIX_W-1:0]     o_pred_pixel;
    logic                 o_block_done;

    sixtap_subpel_interpolator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ref_pixel  (i_ref_pixel),
        .i_sub_x      (i_sub_x),
        .i_sub_y      (i_sub_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pred_pixel (o_pred_pixel),
        .o_block_done (o_block_done)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state, owned by the input monitor.
    logic [DIM_W-1:0] size_w;
    logic [DIM_W-1:0] size_h;
    logic [PIX_W-1:0] line_mem [LINE_ROWS][MAX_WIDTH_DEF];
    logic [PIX_W-1:0] recent_pix [5];
    int               win_row;
    int               win_col;
    logic [SUB_W-1:0] phase_x;
    logic [SUB_W-1:0] phase_y;

    t_pred_word       predicted_pixels [$];
    int               pixel_errors;
    int               words_sent;
    logic             level_fixed = 1'b0;
    logic [PIX_W-1:0] fixed_level = '0;
    t_pace            rx_pace = PACE_STEADY;
    int               ready_hold;
    int               quiet_cycles;

    function automatic int tap_coeff(input logic [SUB_W-1:0] phase, input int k);
        int row [6];
        case (phase)
            3'd0: row = '{0,   0, 128,   0,   0, 0};
            3'd1: row = '{0,  -6, 123,  12,  -1, 0};
            3'd2: row = '{2, -11, 108,  36,  -8, 1};
            3'd3: row = '{0,  -9,  93,  50,  -6, 0};
            3'd4: row = '{3, -16,  77,  77, -16, 3};
            3'd5: row = '{0,  -6,  50,  93,  -9, 0};
            3'd6: row = '{1,  -8,  36, 108, -11, 2};
            default: row = '{0, -1,  12, 123,  -6, 0};
        endcase
        return row[k];
    endfunction

    // Element 0 of the samples is the oldest one.
    function automatic logic [PIX_W-1:0] six_tap(input logic [SUB_W-1:0] phase,
                                                 input logic [5:0][PIX_W-1:0] s);
        int acc;
        acc = ROUND;
        for (int k = 0; k < 6; k++) begin
            acc += tap_coeff(phase, k) * int'(s[k]);
        end
        if (acc < 0) begin
            return '0;
        end
        acc = acc >>> SHIFT;
        if (acc > PIX_MAX) begin
            return PIX_W'(PIX_MAX);
        end
        return acc[PIX_W-1:0];
    endfunction

    function automatic int eff_width(input logic [DIM_W-1:0] w);
        if (w == 0) begin
            return 1;
        end
        return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w);
    endfunction

    function automatic int eff_height(input logic [DIM_W-1:0] h);
        if (h == 0) begin
            return 1;
        end
        return (h > MAX_HEIGHT_EFF) ? MAX_HEIGHT_EFF : int'(h);
    endfunction

    function automatic int draw_pause(input t_pace pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default:     return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] fill_pixel(input t_fill fill, input logic [PIX_W-1:0] level,
                                                    input int row, input int col);
        case (fill)
            FILL_FLAT:    return level;
            FILL_STRIPES: return (((row >> 1) ^ (col >> 1)) & 1) ? 8'd255 : 8'd0;
            FILL_RAMP:    return PIX_W'(row * 37 + col * 11);
            FILL_BINARY:  return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:      return PIX_W'($urandom);
        endcase
    endfunction

    // Moves the window position on by one word and queues the pixel that word completes.
    task automatic interpolate_word(input logic [PIX_W-1:0] pix, input logic [SUB_W-1:0] sx,
                                    input logic [SUB_W-1:0] sy);
        int                     last_col;
        int                     last_row;
        int                     j;
        logic [5:0][PIX_W-1:0]  hs;
        logic [5:0][PIX_W-1:0]  vs;
        logic [PIX_W-1:0]       hval;
        t_pred_word             pw;
        last_col = eff_width(size_w) + 4;
        last_row = eff_height(size_h) + 4;
        if (win_col > last_col) begin
            win_col = last_col;
        end
        if (win_row > last_row) begin
            win_row = last_row;
        end
        if (win_row == 0 && win_col == 0) begin
            phase_x = sx;
            phase_y = sy;
        end
        if (win_col >= 5) begin
            j = win_col - 5;
            for (int k = 0; k < 5; k++) begin
                hs[k] = recent_pix[k];
            end
            hs[5] = pix;
            hval = six_tap(phase_x, hs);
            for (int k = 0; k < LINE_ROWS; k++) begin
                vs[k] = line_mem[k][j];
            end
            vs[5] = hval;
            if (win_row >= 5) begin
                pw.pixel = level_fixed ? fixed_level : six_tap(phase_y, vs);
                pw.done  = (win_row == last_row && win_col == last_col);
                predicted_pixels.push_back(pw);
            end
            for (int k = 0; k < LINE_ROWS - 1; k++) begin
                line_mem[k][j] = vs[k + 1];
            end
            line_mem[LINE_ROWS - 1][j] = hval;
        end
        for (int k = 0; k < 4; k++) begin
            recent_pix[k] = recent_pix[k + 1];
        end
        recent_pix[4] = pix;
        if (win_col >= last_col) begin
            win_col = 0;
            win_row = (win_row >= last_row) ? 0 : win_row + 1;
        end else begin
            win_col = win_col + 1;
        end
    endtask

    // Input and configuration monitor feeding the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_w  = 5'(DIM_RESET);
            size_h  = 5'(DIM_RESET);
            win_row = 0;
            win_col = 0;
            phase_x = '0;
            phase_y = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BLOCK_WIDTH:  size_w = i_cfg_data;
                    REG_BLOCK_HEIGHT: size_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                interpolate_word(i_ref_pixel, i_sub_x, i_sub_y);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_pred_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= 10) begin
                    $display("unexpected word: pixel %0d done %0b", o_pred_pixel, o_block_done);
                end
            end else begin
                want = predicted_pixels.pop_front();
                if (want.pixel !== o_pred_pixel || want.done !== o_block_done) begin
                    pixel_errors++;
                    if (pixel_errors <= 10) begin
                        $display("mismatch: expected pixel %0d done %0b, got pixel %0d done %0b",
                                 want.pixel, want.done, o_pred_pixel, o_block_done);
                    end
                end
            end
        end
    end

    // Receiver: after each accepted word it holds ready low for a drawn number of cycles.
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) begin
                i_ready <= 1'b1;
            end
        end else if (!i_ready) begin
            i_ready <= 1'b1;
        end else if (o_valid) begin
            if ($urandom_range(0, 63) == 0) begin
                rx_pace = t_pace'($urandom_range(0, 2));
            end
            stall = draw_pause(rx_pace);
            if (stall != 0) begin
                i_ready    <= 1'b0;
                ready_hold <= stall;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [PIX_W-1:0] pix, input logic [SUB_W-1:0] sx,
                             input logic [SUB_W-1:0] sy, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_ref_pixel <= pix;
        i_sub_x     <= sx;
        i_sub_y     <= sy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_block_size(input logic [1:0] mask, input logic [DIM_W-1:0] w,
                                    input logic [DIM_W-1:0] h);
        if (mask[0]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_BLOCK_WIDTH;
            i_cfg_data  <= w;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        if (mask[1]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_BLOCK_HEIGHT;
            i_cfg_data  <= h;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // The first edge lets the monitor queue what the last accepted word completes.
    task automatic wait_drained();
        @(posedge i_clk);
        while (predicted_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Streams one whole window; the offsets only count on its first word.
    task automatic stream_window(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                 input logic [SUB_W-1:0] sx, input logic [SUB_W-1:0] sy,
                                 input t_fill fill, input logic [PIX_W-1:0] level,
                                 input t_pace pace);
        int rows;
        int cols;
        rows = eff_height(h) + 5;
        cols = eff_width(w) + 5;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (r == 0 && c == 0) begin
                    push_word(fill_pixel(fill, level, r, c), sx, sy, draw_pause(pace));
                end else begin
                    push_word(fill_pixel(fill, level, r, c), SUB_W'($urandom),
                              SUB_W'($urandom), draw_pause(pace));
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        t_window_spec     spec;
        logic [DIM_W-1:0] cur_w;
        logic [DIM_W-1:0] cur_h;
        logic [1:0]       mask;
        int               windows;
        t_fill            fill;
        pixel_errors = 0;
        words_sent   = 0;
        cur_w        = 5'(DIM_RESET);
        cur_h        = 5'(DIM_RESET);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            spec = DIRECTED[i];
            wait_drained();
            if (spec.wr_mask[0]) begin
                cur_w = spec.width;
            end
            if (spec.wr_mask[1]) begin
                cur_h = spec.height;
            end
            write_block_size(spec.wr_mask, spec.width, spec.height);
            level_fixed = spec.fixed;
            fixed_level = spec.level;
            stream_window(cur_w, cur_h, spec.sx, spec.sy, spec.fill, spec.level,
                          t_pace'(i % 3));
        end
        wait_drained();
        level_fixed = 1'b0;

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            wait_drained();
            mask = 2'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                cur_w = DIM_W'($urandom);
                cur_h = ($urandom_range(0, 1) != 0) ? DIM_W'($urandom) : 5'd4;
            end else begin
                case ($urandom_range(0, 4))
                    0, 1:    cur_w = 5'd4;
                    2, 3:    cur_w = 5'd8;
                    default: cur_w = 5'd16;
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    cur_h = 5'd4;
                    2, 3:    cur_h = 5'd8;
                    default: cur_h = 5'd16;
                endcase
            end
            // An unwritten register keeps its old value, so track what the block holds.
            if (!mask[0]) begin
                cur_w = size_w;
            end
            if (!mask[1]) begin
                cur_h = size_h;
            end
            write_block_size(mask, cur_w, cur_h);
            windows = $urandom_range(1, 2);
            for (int n = 0; n < windows; n++) begin
                case ($urandom_range(0, 9))
                    0:       fill = FILL_BINARY;
                    1:       fill = FILL_STRIPES;
                    2:       fill = FILL_FLAT;
                    default: fill = FILL_NOISE;
                endcase
                stream_window(cur_w, cur_h, SUB_W'($urandom), SUB_W'($urandom), fill,
                              PIX_W'($urandom), t_pace'($urandom_range(0, 2)));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pixel_errors == 0 && predicted_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
